FILE: rtl/cdf97_pkg.sv
`default_nettype none

package cdf97_pkg;

  // Fixed field and datapath widths.
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SUM_W    = WORD_W + 1;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned PROD_W   = SUM_W + COEF_W;
  localparam int unsigned QSHIFT   = 14;
  localparam int unsigned QHALF    = 8192;
  localparam int unsigned TERM_W   = PROD_W + 1 - QSHIFT;
  localparam int unsigned CIDX_W   = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Lifting and scaling coefficients in Q2.14.
  localparam logic signed [COEF_W-1:0] CA1 = -16'sd25987;
  localparam logic signed [COEF_W-1:0] CA2 = -16'sd868;
  localparam logic signed [COEF_W-1:0] CA3 = 16'sd14466;
  localparam logic signed [COEF_W-1:0] CA4 = 16'sd7266;
  localparam logic signed [COEF_W-1:0] CK1 = 16'sd13318;
  localparam logic signed [COEF_W-1:0] CK2 = 16'sd10078;

  typedef enum logic [2:0] {
    COEF_A1,
    COEF_A2,
    COEF_A3,
    COEF_A4,
    COEF_K1,
    COEF_K2
  } coef_sel_e;

  typedef struct packed {
    logic      en;
    coef_sel_e sel;
  } mac_ctl_t;

  function automatic logic signed [COEF_W-1:0] coef_value(input coef_sel_e sel);
    logic signed [COEF_W-1:0] val;
    case (sel)
      COEF_A1: val = CA1;
      COEF_A2: val = CA2;
      COEF_A3: val = CA3;
      COEF_A4: val = CA4;
      COEF_K1: val = CK1;
      COEF_K2: val = CK2;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cdf97_lifting_column_transform_top.sv
`default_nettype none

// Forward CDF 9/7 lifting wavelet, one level, on one column of samples.
// Input channel (in_valid_i/in_ready_o, sample_in_i): one Q16.8 sample per
// transfer. After the last sample of a column the block runs the four lifting
// passes and then sends len coefficients on the output channel
// (out_valid_o/out_ready_i): all low-band ones by index, then all high-band
// ones; last_o marks the final high-band coefficient.
// Configuration channel (cfg_valid_i/cfg_ready_o, column_length_i) is taken
// only while the block is loading, and the input channel holds off while a
// write is offered; a write drops any partly loaded column.
// The length is forced even and clamped to 4..MAX_LEN.
// Per column of len samples: loading takes one sample a cycle while no write
// is offered; then four lifting passes over len/2 rows, each row stepping
// through the single column store read port and shared multiplier; then each
// coefficient is read, scaled and emitted in turn.
// The output register holds a coefficient until it is taken; a stalled
// receiver stalls the sequencer, and after the final coefficient is computed
// the block takes new samples while that coefficient still waits.
module cdf97_lifting_column_transform_top #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [cdf97_pkg::CFG_W-1:0]           column_length_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic signed [cdf97_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [cdf97_pkg::SAMPLE_W-1:0]      coefficient_o,
  output logic                                       band_high_o,
  output logic [cdf97_pkg::CIDX_W-1:0]               coef_index_o,
  output logic                                       last_o
);

  localparam int unsigned AW       = $clog2(MAX_LEN);
  localparam int unsigned LEN_W    = $clog2(MAX_LEN + 1);
  localparam int unsigned MAX_EVEN = MAX_LEN - (MAX_LEN % 2);
  localparam int unsigned XW       = cdf97_pkg::TERM_W + 1;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_LIFT = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  // Row phases. Lifting: read left, read right, read self, multiply, write.
  // Output: read row, multiply, emit.
  localparam logic [2:0] PH_S0 = 3'd0;
  localparam logic [2:0] PH_S1 = 3'd1;
  localparam logic [2:0] PH_S2 = 3'd2;
  localparam logic [2:0] PH_S3 = 3'd3;
  localparam logic [2:0] PH_S4 = 3'd4;

  localparam logic [1:0] PASS_LAST = 2'd3;

  // Saturate a lifted sum to 32 bits.
  function automatic logic signed [cdf97_pkg::WORD_W-1:0] sat32(
    input logic signed [XW-1:0] v
  );
    logic signed [cdf97_pkg::WORD_W-1:0] r;
    if ((&v[XW-1:cdf97_pkg::WORD_W-1]) || !(|v[XW-1:cdf97_pkg::WORD_W-1])) begin
      r = v[cdf97_pkg::WORD_W-1:0];
    end else if (v[XW-1]) begin
      r = {1'b1, {(cdf97_pkg::WORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(cdf97_pkg::WORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturate a scaled coefficient to 24 bits.
  function automatic logic signed [cdf97_pkg::SAMPLE_W-1:0] sat24(
    input logic signed [cdf97_pkg::TERM_W-1:0] v
  );
    logic signed [cdf97_pkg::SAMPLE_W-1:0] r;
    if ((&v[cdf97_pkg::TERM_W-1:cdf97_pkg::SAMPLE_W-1])
        || !(|v[cdf97_pkg::TERM_W-1:cdf97_pkg::SAMPLE_W-1])) begin
      r = v[cdf97_pkg::SAMPLE_W-1:0];
    end else if (v[cdf97_pkg::TERM_W-1]) begin
      r = {1'b1, {(cdf97_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(cdf97_pkg::SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Control state.
  logic [1:0]                  state_q, state_d;
  logic [2:0]                  ph_q, ph_d;
  logic [1:0]                  pass_q, pass_d;
  logic [AW-1:0]               row_q, row_d;
  logic                        band_q, band_d;
  logic [LEN_W-1:0]            load_cnt_q, load_cnt_d;
  logic [cdf97_pkg::CFG_W-1:0] cfg_q, cfg_d;
  logic                        out_valid_q, out_valid_d;

  // Datapath registers.
  logic signed [cdf97_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic signed [cdf97_pkg::WORD_W-1:0]   self_q, self_d;
  logic signed [cdf97_pkg::SAMPLE_W-1:0] out_coef_q, out_coef_d;
  logic                                  out_band_q, out_band_d;
  logic [cdf97_pkg::CIDX_W-1:0]          out_idx_q, out_idx_d;
  logic                                  out_last_q, out_last_d;

  logic [cdf97_pkg::CFG_W-1:0] len_even;
  logic [LEN_W-1:0]            len;
  logic [LEN_W-1:0]            row_x;
  logic                        end_of_pass;
  logic                        is_last_row;
  logic                        odd_pass;
  logic [AW-1:0]               left_addr, right_addr;

  logic                                in_fire, cfg_fire, out_free;
  logic                                mem_we;
  logic [AW-1:0]                       mem_waddr, mem_raddr;
  logic signed [cdf97_pkg::WORD_W-1:0] mem_wdata, mem_rdata;
  cdf97_pkg::mac_ctl_t                 mac_ctl;
  logic signed [cdf97_pkg::SUM_W-1:0]  mac_op;
  logic signed [cdf97_pkg::TERM_W-1:0] mac_term;
  logic signed [cdf97_pkg::WORD_W-1:0] lifted;

  // Effective column length: even, at least 4, at most the store depth.
  always_comb begin
    len_even = cfg_q & ~cdf97_pkg::CFG_W'(1);
    if (len_even < cdf97_pkg::CFG_W'(4)) begin
      len = LEN_W'(4);
    end else if (len_even > cdf97_pkg::CFG_W'(MAX_EVEN)) begin
      len = LEN_W'(MAX_EVEN);
    end else begin
      len = LEN_W'(len_even);
    end
  end

  // Row bookkeeping. Odd passes update odd rows; the last odd row mirrors its
  // right neighbor, and row 0 mirrors its left neighbor in the even passes.
  always_comb begin
    row_x       = LEN_W'(row_q);
    end_of_pass = ({1'b0, row_x} + (LEN_W + 1)'(2)) >= {1'b0, len};
    is_last_row = row_x == (len - LEN_W'(1));
    odd_pass    = ~pass_q[0];
    if (!odd_pass && row_q == '0) begin
      left_addr = AW'(1);
    end else begin
      left_addr = row_q - AW'(1);
    end
    if (odd_pass && is_last_row) begin
      right_addr = row_q - AW'(1);
    end else begin
      right_addr = row_q + AW'(1);
    end
  end

  // A configuration write wins over a sample offered in the same cycle; the
  // sample waits and is taken as the first one after the write.
  assign in_ready_o  = (state_q == ST_LOAD) && !cfg_valid_i;
  assign cfg_ready_o = state_q == ST_LOAD;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // Column store ports.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_q;
    mem_wdata = lifted;
    mem_raddr = row_q;
    case (state_q)
      ST_LOAD: begin
        mem_we    = in_fire && !cfg_fire;
        mem_waddr = load_cnt_q[AW-1:0];
        mem_wdata = cdf97_pkg::WORD_W'(sample_in_i);
      end
      ST_LIFT: begin
        mem_we = ph_q == PH_S4;
        case (ph_q)
          PH_S0:   mem_raddr = left_addr;
          PH_S1:   mem_raddr = right_addr;
          default: mem_raddr = row_q;
        endcase
      end
      default: begin
        mem_raddr = row_q;
      end
    endcase
  end

  cdf97_colmem #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_colmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Shared multiplier control: lifting coefficient by pass, or the band scale.
  always_comb begin
    mac_ctl.en = ((state_q == ST_LIFT) && (ph_q == PH_S3))
              || ((state_q == ST_OUT) && (ph_q == PH_S1));
    if (state_q == ST_LIFT) begin
      mac_op = sum_q;
      case (pass_q)
        2'd0:    mac_ctl.sel = cdf97_pkg::COEF_A1;
        2'd1:    mac_ctl.sel = cdf97_pkg::COEF_A2;
        2'd2:    mac_ctl.sel = cdf97_pkg::COEF_A3;
        default: mac_ctl.sel = cdf97_pkg::COEF_A4;
      endcase
    end else begin
      mac_op      = cdf97_pkg::SUM_W'(mem_rdata);
      mac_ctl.sel = band_q ? cdf97_pkg::COEF_K2 : cdf97_pkg::COEF_K1;
    end
  end

  cdf97_mac u_mac (
    .clk_i  (clk_i),
    .ctl_i  (mac_ctl),
    .op_i   (mac_op),
    .term_o (mac_term)
  );

  assign lifted = sat32(XW'(self_q) + XW'(mac_term));

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    pass_d      = pass_q;
    row_d       = row_q;
    band_d      = band_q;
    load_cnt_d  = load_cnt_q;
    cfg_d       = cfg_q;
    out_valid_d = out_valid_q;
    sum_d       = sum_q;
    self_d      = self_q;
    out_coef_d  = out_coef_q;
    out_band_d  = out_band_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_LOAD: begin
        if (cfg_fire) begin
          cfg_d      = column_length_i;
          load_cnt_d = '0;
        end else if (in_fire) begin
          if (load_cnt_q == (len - LEN_W'(1))) begin
            load_cnt_d = '0;
            state_d    = ST_LIFT;
            ph_d       = PH_S0;
            pass_d     = '0;
            row_d      = AW'(1);
          end else begin
            load_cnt_d = load_cnt_q + LEN_W'(1);
          end
        end
      end

      ST_LIFT: begin
        case (ph_q)
          PH_S0: begin
            ph_d = PH_S1;
          end
          PH_S1: begin
            sum_d = cdf97_pkg::SUM_W'(mem_rdata);
            ph_d  = PH_S2;
          end
          PH_S2: begin
            sum_d = sum_q + cdf97_pkg::SUM_W'(mem_rdata);
            ph_d  = PH_S3;
          end
          PH_S3: begin
            self_d = mem_rdata;
            ph_d   = PH_S4;
          end
          default: begin
            ph_d = PH_S0;
            if (end_of_pass) begin
              if (pass_q == PASS_LAST) begin
                state_d = ST_OUT;
                row_d   = '0;
                band_d  = 1'b0;
              end else begin
                pass_d = pass_q + 2'd1;
                row_d  = AW'(pass_q[0]);
              end
            end else begin
              row_d = row_q + AW'(2);
            end
          end
        endcase
      end

      ST_OUT: begin
        case (ph_q)
          PH_S0: begin
            ph_d = PH_S1;
          end
          PH_S1: begin
            ph_d = PH_S2;
          end
          default: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_coef_d  = sat24(mac_term);
              out_band_d  = band_q;
              out_idx_d   = cdf97_pkg::CIDX_W'(row_q >> 1);
              out_last_d  = band_q && is_last_row;
              ph_d        = PH_S0;
              if (band_q) begin
                if (is_last_row) begin
                  state_d = ST_LOAD;
                end else begin
                  row_d = row_q + AW'(2);
                end
              end else if (end_of_pass) begin
                band_d = 1'b1;
                row_d  = AW'(1);
              end else begin
                row_d = row_q + AW'(2);
              end
            end
          end
        endcase
      end

      default: begin
        state_d = ST_LOAD;
        ph_d    = PH_S0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      ph_q        <= PH_S0;
      pass_q      <= '0;
      row_q       <= '0;
      band_q      <= 1'b0;
      load_cnt_q  <= '0;
      cfg_q       <= cdf97_pkg::CFG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      pass_q      <= pass_d;
      row_q       <= row_d;
      band_q      <= band_d;
      load_cnt_q  <= load_cnt_d;
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    self_q     <= self_d;
    out_coef_q <= out_coef_d;
    out_band_q <= out_band_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = out_coef_q;
  assign band_high_o   = out_band_q;
  assign coef_index_o  = out_idx_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/cdf97_colmem.sv
`default_nettype none

// Column store: one write port, one read port with registered read data.
module cdf97_colmem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [AW-1:0]                       waddr_i,
  input  wire logic signed [cdf97_pkg::WORD_W-1:0] wdata_i,
  input  wire logic [AW-1:0]                       raddr_i,
  output logic signed [cdf97_pkg::WORD_W-1:0]      rdata_o
);

  logic signed [cdf97_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/cdf97_mac.sv
`default_nettype none

// Shared multiplier: registered product of an operand and a selected
// coefficient, followed by round-half-up and the Q2.14 shift.
module cdf97_mac (
  input  wire logic                                clk_i,
  input  wire cdf97_pkg::mac_ctl_t                 ctl_i,
  input  wire logic signed [cdf97_pkg::SUM_W-1:0]  op_i,
  output logic signed [cdf97_pkg::TERM_W-1:0]      term_o
);

  logic signed [cdf97_pkg::COEF_W-1:0] coef;
  logic signed [cdf97_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [cdf97_pkg::PROD_W:0]          rnd;

  always_comb begin
    coef = cdf97_pkg::coef_value(ctl_i.sel);
    if (ctl_i.en) begin
      prod_d = op_i * coef;
    end else begin
      prod_d = prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_comb begin
    rnd    = {prod_q[cdf97_pkg::PROD_W-1], prod_q}
           + (cdf97_pkg::PROD_W + 1)'(cdf97_pkg::QHALF);
    term_o = rnd[cdf97_pkg::PROD_W:cdf97_pkg::QSHIFT];
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cdf97_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // One coefficient as the block presents it on the output channel.
  typedef struct {
    sample_t           coef;
    logic              band_high;
    logic [CIDX_W-1:0] index;
    logic              is_last;
  } coef_rec_t;

  localparam int unsigned MAX_LEN     = 64;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam sample_t     S_MAX       = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t     S_MIN       = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // The scoreboard keeps its own copy of the column store, the load position
  // and the length register. Each sample that completes a column runs the
  // four lifting passes and the scaling, and queues the coefficients in the
  // order the block must send them: all low-band ones, then all high-band ones.
  class coef_scoreboard;
    int               column[MAX_LEN];
    int unsigned      loaded;
    logic [CFG_W-1:0] length_reg;
    coef_rec_t        pending_coefs[$];
    int unsigned      checked;
    int unsigned      errors;

    function new();
      loaded     = 0;
      length_reg = CFG_RESET;
      checked    = 0;
      errors     = 0;
    endfunction

    // The length is forced even and clamped to 4..MAX_LEN.
    function int unsigned column_len();
      int unsigned len;
      len = 32'(length_reg & 7'h7E);
      if (len < 4) len = 4;
      if (len > (MAX_LEN & ~1)) len = MAX_LEN & ~1;
      return len;
    endfunction

    // A new length also drops whatever part of a column was loaded.
    function void set_length(input logic [CFG_W-1:0] value);
      length_reg = value;
      loaded     = 0;
    endfunction

    // Q2.14 product, rounded with halves going toward plus infinity.
    function longint scale_round(input longint c, input longint x);
      return (c * x + longint'(QHALF)) >>> QSHIFT;
    endfunction

    function int clip32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
    endfunction

    function sample_t clip24(input longint v);
      if (v > longint'(S_MAX)) return S_MAX;
      if (v < longint'(S_MIN)) return S_MIN;
      return sample_t'(v);
    endfunction

    // One in-place lifting pass. At the column ends the missing neighbor is
    // mirrored, so the last odd row and row 0 take twice their one neighbor.
    function void lift(input bit odd_rows, input longint c, input int unsigned len);
      if (odd_rows) begin
        for (int r = 1; r + 1 < len; r += 2)
          column[r] = clip32(column[r] +
                             scale_round(c, longint'(column[r-1]) + column[r+1]));
        column[len-1] = clip32(column[len-1] +
                               scale_round(c, 2 * longint'(column[len-2])));
      end else begin
        for (int r = 2; r < len; r += 2)
          column[r] = clip32(column[r] +
                             scale_round(c, longint'(column[r-1]) + column[r+1]));
        column[0] = clip32(column[0] + scale_round(c, 2 * longint'(column[1])));
      end
    endfunction

    function void take_sample(input sample_t s);
      int unsigned len;
      int unsigned half;
      coef_rec_t   rec;
      len = column_len();
      if (loaded >= len) loaded = 0;
      column[loaded] = int'(s);
      loaded++;
      if (loaded < len) return;
      loaded = 0;
      lift(1'b1, CA1, len);
      lift(1'b0, CA2, len);
      lift(1'b1, CA3, len);
      lift(1'b0, CA4, len);
      half = len / 2;
      for (int k = 0; k < half; k++) begin
        rec.coef      = clip24(scale_round(CK1, column[2*k]));
        rec.band_high = 1'b0;
        rec.index     = k[CIDX_W-1:0];
        rec.is_last   = 1'b0;
        pending_coefs.push_back(rec);
      end
      for (int k = 0; k < half; k++) begin
        rec.coef      = clip24(scale_round(CK2, column[2*k+1]));
        rec.band_high = 1'b1;
        rec.index     = k[CIDX_W-1:0];
        rec.is_last   = (k + 1 == half);
        pending_coefs.push_back(rec);
      end
    endfunction

    function void check_coef(input sample_t coef, input logic band_high,
                             input logic [CIDX_W-1:0] index, input logic is_last);
      coef_rec_t want;
      checked++;
      if (pending_coefs.size() == 0) begin
        $error("coefficient %0d arrived with none expected", coef);
        errors++;
        return;
      end
      want = pending_coefs.pop_front();
      if (coef !== want.coef) begin
        $error("coefficient: expected %0d, got %0d", want.coef, coef);
        errors++;
      end
      if (band_high !== want.band_high) begin
        $error("band_high: expected %0d, got %0d", want.band_high, band_high);
        errors++;
      end
      if (index !== want.index) begin
        $error("coef_index: expected %0d, got %0d", want.index, index);
        errors++;
      end
      if (is_last !== want.is_last) begin
        $error("last: expected %0d, got %0d", want.is_last, is_last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_coefs.size();
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_valid     = 1'b0;
  logic [CFG_W-1:0] column_length = '0;
  logic             in_valid      = 1'b0;
  sample_t          sample_in     = '0;
  logic             out_ready     = 1'b0;

  logic              cfg_ready_o;
  logic              in_ready_o;
  logic              out_valid_o;
  sample_t           coefficient_o;
  logic              band_high_o;
  logic [CIDX_W-1:0] coef_index_o;
  logic              last_o;

  coef_scoreboard sb;
  int unsigned    cycle_count = 0;
  int unsigned    burst_left  = 0;

  cdf97_lifting_column_transform_top #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .column_length_i(column_length),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .sample_in_i    (sample_in),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .coefficient_o  (coefficient_o),
    .band_high_o    (band_high_o),
    .coef_index_o   (coef_index_o),
    .last_o         (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // A generous ceiling on the run. A hang anywhere ends up here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("cdf97_lifting_column_transform_top test failed");
      $finish;
    end
  end

  // Every coefficient transfer is checked against the oldest expectation.
  // Outputs are sampled at the rising edge, before the block updates them.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready)
      sb.check_coef(coefficient_o, band_high_o, coef_index_o, last_o);
  end

  // The receiver changes its stall pattern after each random span: always
  // ready, coin flip, mostly stalled, or mostly ready. Twice during the run,
  // once enough coefficients are checked and the sender is waiting with a
  // sample, it holds off for a long stretch so that the output register
  // fills, the sequencer stops, and the sender stays blocked.
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned hold_no;
    int unsigned hold_at[2];
    hold_at = '{60, 300};
    hold_no = 0;
    wait (rst_ni === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk_i);
        if (hold_no < 2 && sb.checked >= hold_at[hold_no] && in_valid && !in_ready_o) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk_i);
          hold_no++;
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offers one sample and returns at the edge where it is taken. The sender
  // works in bursts of random length; between bursts valid drops for a
  // random gap, and a quarter of the bursts follow on with no gap at all.
  // Valid is left high after a transfer so that back-to-back samples never
  // see it lowered and raised within one time step.
  task automatic send_sample(input sample_t s);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid  <= 1'b1;
    sample_in <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_sample(s);
  endtask

  // Drops valid and waits until every expected coefficient has come back,
  // plus a short margin for the block to return to loading.
  task automatic settle();
    @(negedge clk_i);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Length writes happen only while nothing is expected back.
  task automatic write_length(input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_valid     <= 1'b1;
    column_length <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_length(value);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Sample styles: full-range random bits, small values near zero, the
  // extremes, zero and minus one, and large values of either sign.
  function automatic sample_t pick_sample(input int unsigned style);
    case (style)
      0: return sample_t'($urandom);
      1: return sample_t'($urandom_range(0, 4095) - 2048);
      2: begin
        case ($urandom_range(0, 3))
          0:       return S_MAX;
          1:       return S_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return $urandom_range(0, 1) ? S_MAX - sample_t'($urandom_range(0, 65535))
                                          : S_MIN + sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin : stimulus
    sample_t          dir_cols[4][4];
    logic [CFG_W-1:0] fixed_len[4];
    logic [CFG_W-1:0] value;
    int unsigned      phase;
    int unsigned      items;
    int unsigned      len;
    int unsigned      ncols;
    int unsigned      style;
    int unsigned      part;

    sb = new();
    dir_cols[0] = '{S_MAX, S_MIN, S_MAX, S_MIN};
    dir_cols[1] = '{S_MIN, S_MAX, S_MIN, S_MAX};
    dir_cols[2] = '{S_MAX, S_MAX, S_MAX, S_MAX};
    dir_cols[3] = '{'0, '1, 24'sd1, '0};
    fixed_len   = '{7'd64, 7'd127, 7'd1, 7'd63};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. A length of zero clamps to the shortest column; the
    // columns hit both saturation limits, a flat column and tiny values.
    write_length(7'd0);
    foreach (dir_cols[c])
      foreach (dir_cols[c][j])
        send_sample(dir_cols[c][j]);
    settle();

    // A length write in the middle of a column throws the partial column
    // away. The odd length five is forced down to four.
    send_sample(S_MAX);
    send_sample(S_MIN);
    settle();
    write_length(7'd5);
    send_sample(24'sd256);
    send_sample(-24'sd256);
    send_sample(S_MIN);
    send_sample(24'sd1);

    // Random part. The first phases pin the long and out-of-range lengths;
    // later ones are mostly short columns with an occasional long one. Some
    // phases end in a broken, partly loaded column that the next length
    // write discards.
    phase = 0;
    items = 0;
    while (items < 450) begin
      if (phase < 4)
        value = fixed_len[phase];
      else if ($urandom_range(0, 5) == 0)
        value = CFG_W'($urandom_range(62, 127));
      else
        value = CFG_W'($urandom_range(0, 20));
      settle();
      write_length(value);
      len   = sb.column_len();
      ncols = (len > 32) ? 1 : $urandom_range(2, 6);
      repeat (ncols) begin
        style = $urandom_range(0, 3);
        repeat (len) begin
          send_sample(pick_sample(style));
          items++;
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        part = $urandom_range(1, len - 1);
        repeat (part) send_sample(pick_sample(0));
      end
      phase++;
    end

    settle();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0)
      $display("cdf97_lifting_column_transform_top test passed");
    else
      $display("cdf97_lifting_column_transform_top test failed");
    $finish;
  end

endmodule
